### sv/mm4r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4r_pkg
// Shared constants and types for the row-at-a-time 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4r_pkg;

   localparam int DIM        = 4;
   localparam int PORT_WIDTH = 32;
   localparam int ROW_WIDTH  = 2;

   typedef enum logic [0:0] {
      OP_LOAD     = 1'b0,
      OP_MULTIPLY = 1'b1
   } opcode_type;

endpackage
`default_nettype wire

### sv/matrix4x4_row_multiply_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4x4_row_multiply_top
// Usage: Q16.16 4x4 matrix product, one left-hand row per request.
// A load request (opcode 0) writes one right-hand row into the local store and
// gives no response. A multiply request (opcode 1) carries one left-hand row
// and gives the product row, rounded to nearest and saturated, with a flag
// set when any element was clipped.
// Channels: req_* in, rsp_* out, valid/stall on each; a request moves on an
// edge with valid high and stall low.
// Pipeline: an accepted multiply request passes through the input register,
// sixteen parallel multipliers, pair add, final add with rounding, then
// round/saturate into the output register, which presents the response.
// Throughput: one request per cycle while req_stall is low, loads and multiplies alike.
// A load takes effect for the next request accepted after it.
// Reset clears all stage valids; the store stays undefined until loaded.
// A stalled response holds; the pipeline fills behind it and req_stall
// rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module matrix4x4_row_multiply_top
   import mm4r_pkg::*;
#(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [ROW_WIDTH-1:0]          req_row_index,
   input  wire logic signed [PORT_WIDTH-1:0]  req_elem_0,
   input  wire logic signed [PORT_WIDTH-1:0]  req_elem_1,
   input  wire logic signed [PORT_WIDTH-1:0]  req_elem_2,
   input  wire logic signed [PORT_WIDTH-1:0]  req_elem_3,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [PORT_WIDTH-1:0]       rsp_prod_0,
   output logic signed [PORT_WIDTH-1:0]       rsp_prod_1,
   output logic signed [PORT_WIDTH-1:0]       rsp_prod_2,
   output logic signed [PORT_WIDTH-1:0]       rsp_prod_3,
   output logic                               rsp_saturated
);

   localparam int PW = 2 * ELEM_WIDTH;
   localparam int SW = 2 * ELEM_WIDTH + 2;
   localparam logic signed [SW-1:0] HALF_V = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] MAX_V  = (SW'(1) <<< (ELEM_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] MIN_V  = -(SW'(1) <<< (ELEM_WIDTH - 1));

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PW-1:0]         prod_type;
   typedef logic signed [SW-1:0]         sum_type;

   logic     req_accept;
   elem_type req_elems [DIM];

   elem_type store_ff [DIM][DIM];

   logic     s1_valid_ff, s1_valid_in, s1_ready;
   elem_type s1_a_ff [DIM];

   logic     s2_valid_ff, s2_valid_in, s2_ready;
   prod_type s2_prod_ff [DIM][DIM];
   prod_type s2_prod_in [DIM][DIM];

   logic     s3_valid_ff, s3_valid_in, s3_ready;
   sum_type  s3_pair_ff [DIM][2];
   sum_type  s3_pair_in [DIM][2];

   logic     s4_valid_ff, s4_valid_in, s4_ready;
   sum_type  s4_sum_ff [DIM];
   sum_type  s4_sum_in [DIM];

   logic     out_valid_ff, out_valid_in, out_ready;
   elem_type out_prod_ff [DIM];
   elem_type out_prod_in [DIM];
   logic     out_sat_ff, out_sat_in;

   assign req_elems[0] = req_elem_0[ELEM_WIDTH-1:0];
   assign req_elems[1] = req_elem_1[ELEM_WIDTH-1:0];
   assign req_elems[2] = req_elem_2[ELEM_WIDTH-1:0];
   assign req_elems[3] = req_elem_3[ELEM_WIDTH-1:0];

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? (req_accept && (opcode_type'(req_opcode) == OP_MULTIPLY))
                              : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
      s4_valid_in  = s4_ready ? s3_valid_ff : s4_valid_ff;
      out_valid_in = out_ready ? s4_valid_ff : out_valid_ff;
   end

   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int j = 0; j < DIM; j++) begin
            s2_prod_in[k][j] = s1_a_ff[k] * store_ff[k][j];
         end
      end
      for (int j = 0; j < DIM; j++) begin
         s3_pair_in[j][0] = SW'(s2_prod_ff[0][j]) + SW'(s2_prod_ff[1][j]);
         s3_pair_in[j][1] = SW'(s2_prod_ff[2][j]) + SW'(s2_prod_ff[3][j]);
         s4_sum_in[j]     = s3_pair_ff[j][0] + s3_pair_ff[j][1] + HALF_V;
      end
   end

   always_comb begin
      sum_type shifted;
      out_sat_in = 1'b0;
      for (int j = 0; j < DIM; j++) begin
         shifted = s4_sum_ff[j] >>> FRAC_BITS;
         if (shifted > MAX_V) begin
            out_prod_in[j] = MAX_V[ELEM_WIDTH-1:0];
            out_sat_in     = 1'b1;
         end else if (shifted < MIN_V) begin
            out_prod_in[j] = MIN_V[ELEM_WIDTH-1:0];
            out_sat_in     = 1'b1;
         end else begin
            out_prod_in[j] = shifted[ELEM_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // store the right-hand row
   always_ff @(posedge clock) begin
      if (req_accept && (opcode_type'(req_opcode) == OP_LOAD)
            && (int'(req_row_index) < DIM)) begin
         for (int k = 0; k < DIM; k++) begin
            store_ff[req_row_index][k] <= req_elems[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_a_ff <= req_elems;
      end
      if (s2_ready) begin
         s2_prod_ff <= s2_prod_in;
      end
      if (s3_ready) begin
         s3_pair_ff <= s3_pair_in;
      end
      if (s4_ready) begin
         s4_sum_ff <= s4_sum_in;
      end
      if (out_ready) begin
         out_prod_ff <= out_prod_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_prod_0    = PORT_WIDTH'(unsigned'(out_prod_ff[0]));
   assign rsp_prod_1    = PORT_WIDTH'(unsigned'(out_prod_ff[1]));
   assign rsp_prod_2    = PORT_WIDTH'(unsigned'(out_prod_ff[2]));
   assign rsp_prod_3    = PORT_WIDTH'(unsigned'(out_prod_ff[3]));
   assign rsp_saturated = out_sat_ff;

endmodule
`default_nettype wire

### verif/tb_matrix4x4_row_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_row_multiply_top
// Self-checking bench for the Q16.16 row-at-a-time 4x4 matrix multiplier.
// Loads right-hand rows and streams left-hand rows through the request
// channel. An in-order software copy of the right-hand store predicts each
// product row: exact sums, round half up, clip to 32 bits. Every response is
// compared field by field with the oldest prediction. Directed cases cover
// identity, clipping in both directions and rounding at exact halves. Random
// traffic follows under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_matrix4x4_row_multiply_top
   import mm4r_pkg::*;
();

   localparam logic [PORT_WIDTH-1:0] ONE   = 32'h0001_0000;
   localparam logic [PORT_WIDTH-1:0] HALF  = 32'h0000_8000;
   localparam logic [PORT_WIDTH-1:0] MAX_Q = 32'h7FFF_FFFF;
   localparam logic [PORT_WIDTH-1:0] MIN_Q = 32'h8000_0000;
   localparam logic [PORT_WIDTH-1:0] NEG_LSB = 32'hFFFF_FFFF;
   localparam logic [PORT_WIDTH-1:0] ZERO  = 32'h0000_0000;

   typedef struct packed {
      logic [DIM-1:0][PORT_WIDTH-1:0] prod;
      logic                           saturated;
   } product_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = 1'b0;
   logic [ROW_WIDTH-1:0]          req_row_index = '0;
   logic signed [PORT_WIDTH-1:0]  req_elem_0 = '0;
   logic signed [PORT_WIDTH-1:0]  req_elem_1 = '0;
   logic signed [PORT_WIDTH-1:0]  req_elem_2 = '0;
   logic signed [PORT_WIDTH-1:0]  req_elem_3 = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [PORT_WIDTH-1:0]  rsp_prod_0;
   logic signed [PORT_WIDTH-1:0]  rsp_prod_1;
   logic signed [PORT_WIDTH-1:0]  rsp_prod_2;
   logic signed [PORT_WIDTH-1:0]  rsp_prod_3;
   logic                          rsp_saturated;

   logic [DIM-1:0][DIM-1:0][PORT_WIDTH-1:0] right_rows = '0;
   logic [DIM-1:0]                          rows_loaded = '0;
   product_row_type                         pending_products[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int loads_sent    = 0;
   int products_checked = 0;
   int clipped_rows  = 0;

   matrix4x4_row_multiply_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_row_index (req_row_index),
      .req_elem_0    (req_elem_0),
      .req_elem_1    (req_elem_1),
      .req_elem_2    (req_elem_2),
      .req_elem_3    (req_elem_3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_prod_0    (rsp_prod_0),
      .rsp_prod_1    (rsp_prod_1),
      .rsp_prod_2    (rsp_prod_2),
      .rsp_prod_3    (rsp_prod_3),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic product_row_type predict_product(
      input logic [DIM-1:0][PORT_WIDTH-1:0] left_row);
      logic signed [69:0] acc;
      logic signed [69:0] lhs;
      logic signed [69:0] rhs;
      logic signed [69:0] rounded;
      logic signed [69:0] max_v;
      logic signed [69:0] min_v;
      product_row_type    result;
      max_v = 70'sd2147483647;
      min_v = -70'sd2147483648;
      result.saturated = 1'b0;
      for (int j = 0; j < DIM; j++) begin
         acc = '0;
         for (int k = 0; k < DIM; k++) begin
            lhs = $signed(left_row[k]);
            rhs = $signed(right_rows[k][j]);
            acc = acc + lhs * rhs;
         end
         rounded = (acc + 70'sd32768) >>> 16;
         if (rounded > max_v) begin
            result.prod[j]   = MAX_Q;
            result.saturated = 1'b1;
         end else if (rounded < min_v) begin
            result.prod[j]   = MIN_Q;
            result.saturated = 1'b1;
         end else begin
            result.prod[j] = rounded[PORT_WIDTH-1:0];
         end
      end
      return result;
   endfunction

   task automatic send_request(input opcode_type op, input logic [ROW_WIDTH-1:0] row,
                               input logic [PORT_WIDTH-1:0] e0, input logic [PORT_WIDTH-1:0] e1,
                               input logic [PORT_WIDTH-1:0] e2, input logic [PORT_WIDTH-1:0] e3);
      logic [DIM-1:0][PORT_WIDTH-1:0] elems;
      elems = {e3, e2, e1, e0};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_row_index <= row;
      req_elem_0    <= e0;
      req_elem_1    <= e1;
      req_elem_2    <= e2;
      req_elem_3    <= e3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         right_rows[row]  = elems;
         rows_loaded[row] = 1'b1;
         loads_sent++;
      end else begin
         pending_products.push_back(predict_product(elems));
      end
   endtask

   function automatic logic [PORT_WIDTH-1:0] random_element();
      int pick;
      int v;
      pick = $urandom_range(9);
      if (pick < 5) begin
         v = int'($urandom_range(524288)) - 262144;
      end else if (pick < 7) begin
         v = int'($urandom_range(131072)) - 65536;
      end else if (pick < 9) begin
         v = int'($urandom);
      end else begin
         case ($urandom_range(5))
            0: v = int'(MAX_Q);
            1: v = int'(MIN_Q);
            2: v = int'(NEG_LSB);
            3: v = 1;
            4: v = int'(ONE);
            default: v = 0;
         endcase
      end
      return PORT_WIDTH'(v);
   endfunction

   task automatic test_identity_product();
      send_request(OP_LOAD, 2'd0, ONE, ZERO, ZERO, ZERO);
      send_request(OP_LOAD, 2'd1, ZERO, ONE, ZERO, ZERO);
      send_request(OP_LOAD, 2'd2, ZERO, ZERO, ONE, ZERO);
      send_request(OP_LOAD, 2'd3, ZERO, ZERO, ZERO, ONE);
      send_request(OP_MULTIPLY, 2'd3, MAX_Q, MIN_Q, ONE, NEG_LSB);
      send_request(OP_MULTIPLY, 2'd0, MIN_Q, MAX_Q, NEG_LSB, ZERO);
   endtask

   task automatic test_saturation();
      for (int r = 0; r < DIM; r++)
         send_request(OP_LOAD, ROW_WIDTH'(r), MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      send_request(OP_MULTIPLY, 2'd0, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      send_request(OP_MULTIPLY, 2'd0, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      for (int r = 0; r < DIM; r++)
         send_request(OP_LOAD, ROW_WIDTH'(r), MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      send_request(OP_MULTIPLY, 2'd1, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
   endtask

   task automatic test_rounding_halves();
      send_request(OP_LOAD, 2'd0, HALF, ZERO, ZERO, ZERO);
      send_request(OP_LOAD, 2'd1, ZERO, HALF, ZERO, ZERO);
      send_request(OP_LOAD, 2'd2, ZERO, ZERO, HALF, ZERO);
      send_request(OP_LOAD, 2'd3, ZERO, ZERO, ZERO, HALF);
      send_request(OP_MULTIPLY, 2'd2, 32'd1, NEG_LSB, 32'd3, 32'hFFFF_FFFD);
   endtask

   // loads followed at once by multiplies that land just over the upper limit and exactly at the lower limit
   task automatic test_clip_boundary();
      send_request(OP_LOAD, 2'd0, ONE, ZERO, ZERO, ZERO);
      send_request(OP_LOAD, 2'd1, HALF, ONE, ZERO, ZERO);
      send_request(OP_MULTIPLY, 2'd0, MAX_Q, 32'd1, ZERO, ZERO);
      send_request(OP_MULTIPLY, 2'd0, MIN_Q, NEG_LSB, ZERO, ZERO);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int hold_pct);
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      for (int n = 0; n < count; n++) begin
         if (rows_loaded != '1 || $urandom_range(99) < 25)
            send_request(OP_LOAD, ROW_WIDTH'($urandom_range(DIM - 1)), random_element(),
                         random_element(), random_element(), random_element());
         else
            send_request(OP_MULTIPLY, ROW_WIDTH'($urandom_range(DIM - 1)), random_element(),
                         random_element(), random_element(), random_element());
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_response
      logic [DIM-1:0][PORT_WIDTH-1:0] got;
      product_row_type                want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_prod_3, rsp_prod_2, rsp_prod_1, rsp_prod_0};
         if (pending_products.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual %h sat %b",
                     $time, got, rsp_saturated);
         end else begin
            want = pending_products.pop_front();
            for (int j = 0; j < DIM; j++) begin
               if (got[j] !== want.prod[j]) begin
                  error_count++;
                  $display("%0t: prod_%0d mismatch, expected %h, actual %h",
                           $time, j, want.prod[j], got[j]);
               end
            end
            if (rsp_saturated !== want.saturated) begin
               error_count++;
               $display("%0t: saturated mismatch, expected %b, actual %b",
                        $time, want.saturated, rsp_saturated);
            end
            products_checked++;
            if (want.saturated) clipped_rows++;
         end
      end
   end

   initial begin
      #(12 * 400000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int drain_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9;
      stall_pct     = 67;
      test_identity_product();
      test_saturation();
      test_rounding_halves();
      test_clip_boundary();
      test_random_traffic(567, 9, 67);
      test_random_traffic(567, 67, 9);
      test_random_traffic(566, 0, 0);
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (pending_products.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (pending_products.size() != 0) begin
         error_count++;
         $display("%0t: %0d product rows never returned", $time, pending_products.size());
      end
      $display("Run covered %0d row loads and %0d product rows, %0d of them clipped,",
               loads_sent, products_checked, clipped_rows);
      $display("under sender gaps, receiver stalls and back-to-back traffic.");
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### matrix4x4_row_multiply_top.f
sv/mm4r_pkg.sv
sv/matrix4x4_row_multiply_top.sv
verif/tb_matrix4x4_row_multiply_top.sv
